// File: rtl/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg
// Shared constants and types for the multi-turn angle unwrapper.
// ----------------------------------------------------------------------------
package mau_pkg;

   localparam int ANGLE_BITS_DEFAULT = 12;
   localparam int SAMPLE_WORD_BITS   = 16;
   localparam int TOTAL_BITS         = 32;

   typedef enum logic [0:0] {
      CMD_SAMPLE   = 1'b0,
      CMD_SET_ZERO = 1'b1
   } cmd_type;

endpackage

// File: rtl/mau_if.sv
// ----------------------------------------------------------------------------
// mau_req_if / mau_rsp_if
// Valid/ready channels for angle items and unwrapped results.
// ----------------------------------------------------------------------------
interface mau_req_if
   import mau_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [SAMPLE_WORD_BITS-1:0] sample_word;

   modport source (output valid, output command, output sample_word, input ready);
   modport sink   (input valid, input command, input sample_word, output ready);
endinterface

interface mau_rsp_if
   import mau_pkg::*;
   #(parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT)
   ();
   logic                         valid;
   logic                         ready;
   logic [ANGLE_BITS-1:0]        abs_angle;
   logic [ANGLE_BITS-1:0]        relative_angle;
   logic signed [TOTAL_BITS-1:0] total_counts;
   logic signed [TOTAL_BITS-1:0] total_relative;

   modport source (output valid, output abs_angle, output relative_angle,
                   output total_counts, output total_relative, input ready);
   modport sink   (input valid, input abs_angle, input relative_angle,
                   input total_counts, input total_relative, output ready);
endinterface

// File: rtl/mau_track.sv
// ----------------------------------------------------------------------------
// mau_track
// Tracking state: stored angle, turn count, zero offset and primed flag.
// Presents the post-update state for the result stage.
// ----------------------------------------------------------------------------
module mau_track
   import mau_pkg::*;
   #(parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT)
   (
      input  logic                             clock,
      input  logic                             reset,
      input  logic                             fire,
      input  cmd_type                          command,
      input  logic [ANGLE_BITS-1:0]            angle,
      output logic [ANGLE_BITS-1:0]            last_angle_in,
      output logic [TOTAL_BITS-ANGLE_BITS-1:0] turns_in,
      output logic [ANGLE_BITS-1:0]            zero_point_in
   );

   localparam int TURN_BITS = TOTAL_BITS - ANGLE_BITS;
   localparam logic signed [ANGLE_BITS:0] HALF_TURN = (ANGLE_BITS+1)'(2**(ANGLE_BITS-1));
   localparam logic signed [ANGLE_BITS:0] NEG_HALF_TURN = -HALF_TURN;

   logic [ANGLE_BITS-1:0]        last_angle_ff;
   logic [TURN_BITS-1:0]         turns_ff;
   logic [ANGLE_BITS-1:0]        zero_point_ff;
   logic                         primed_ff;
   logic                         primed_in;
   logic signed [ANGLE_BITS:0]   step;

   // accumulator is always a whole number of turns, so only the turn count is kept
   assign step = $signed({1'b0, angle}) - $signed({1'b0, last_angle_ff});

   always_comb begin
      last_angle_in = last_angle_ff;
      turns_in      = turns_ff;
      zero_point_in = zero_point_ff;
      primed_in     = primed_ff;
      if (fire) begin
         case (command)
            CMD_SAMPLE: begin
               if (primed_ff) begin
                  if (step > HALF_TURN) begin
                     turns_in = turns_ff - TURN_BITS'(1);
                  end else if (step < NEG_HALF_TURN) begin
                     turns_in = turns_ff + TURN_BITS'(1);
                  end
               end
               last_angle_in = angle;
               primed_in     = 1'b1;
            end
            CMD_SET_ZERO: begin
               if (primed_ff) begin
                  zero_point_in = last_angle_ff;
               end
            end
            default: begin
               primed_in = primed_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_angle_ff <= '0;
         turns_ff      <= '0;
         zero_point_ff <= '0;
         primed_ff     <= 1'b0;
      end else begin
         last_angle_ff <= last_angle_in;
         turns_ff      <= turns_in;
         zero_point_ff <= zero_point_in;
         primed_ff     <= primed_in;
      end
   end

endmodule

// File: rtl/mau_result.sv
// ----------------------------------------------------------------------------
// mau_result
// Result register: forms raw, relative and multi-turn totals from the
// updated state and holds the beat until the sink takes it.
// ----------------------------------------------------------------------------
module mau_result
   import mau_pkg::*;
   #(parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT)
   (
      input  logic                             clock,
      input  logic                             reset,
      input  logic                             advance,
      input  logic                             load_valid,
      input  logic [ANGLE_BITS-1:0]            last_angle,
      input  logic [TOTAL_BITS-ANGLE_BITS-1:0] turns,
      input  logic [ANGLE_BITS-1:0]            zero_point,
      mau_rsp_if.source                        rsp_bus
   );

   logic                  valid_ff;
   logic [ANGLE_BITS-1:0] raw_ff;
   logic [ANGLE_BITS-1:0] rel_ff;
   logic [TOTAL_BITS-1:0] total_ff;
   logic [TOTAL_BITS-1:0] trel_ff;
   logic [TOTAL_BITS-1:0] total_in;
   logic [TOTAL_BITS-1:0] trel_in;

   assign total_in = {turns, last_angle};
   assign trel_in  = total_in - {{(TOTAL_BITS-ANGLE_BITS){1'b0}}, zero_point};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load_valid) begin
         raw_ff   <= last_angle;
         // low bits of the relative total are the relative angle modulo a turn
         rel_ff   <= trel_in[ANGLE_BITS-1:0];
         total_ff <= total_in;
         trel_ff  <= trel_in;
      end
   end

   assign rsp_bus.valid          = valid_ff;
   assign rsp_bus.abs_angle      = raw_ff;
   assign rsp_bus.relative_angle = rel_ff;
   assign rsp_bus.total_counts   = $signed(total_ff);
   assign rsp_bus.total_relative = $signed(trel_ff);

endmodule

// File: rtl/multiturn_angle_unwrapper.sv
// ----------------------------------------------------------------------------
// multiturn_angle_unwrapper
// Multi-turn unwrapper for an absolute rotary angle sensor.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the sink keeps up: a sample (low ANGLE_BITS
// of sample_word) or a set-zero command. Each beat yields exactly one result
// beat, passing through the input register and then the result register,
// and a new beat can be accepted every cycle while the sink keeps up; the
// result register holds a stalled beat while the input register takes the
// next one. The first sample after reset only primes the stored angle;
// set-zero before that is ignored. A step of more than half a turn adjusts
// the turn count by one turn; totals wrap in 32-bit two's complement.
// ----------------------------------------------------------------------------
module multiturn_angle_unwrapper
   import mau_pkg::*;
   #(parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT)
   (
      input  logic      clock,
      input  logic      reset,
      mau_req_if.sink   req_bus,
      mau_rsp_if.source rsp_bus
   );

   localparam int TURN_BITS = TOTAL_BITS - ANGLE_BITS;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   cmd_type               s1_cmd_ff;
   logic [ANGLE_BITS-1:0] s1_angle_ff;
   logic                  advance;
   logic                  req_take;
   logic [ANGLE_BITS-1:0] last_angle_in;
   logic [TURN_BITS-1:0]  turns_in;
   logic [ANGLE_BITS-1:0] zero_point_in;

   assign advance       = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff   <= cmd_type'(req_bus.command);
         s1_angle_ff <= req_bus.sample_word[ANGLE_BITS-1:0];
      end
   end

   mau_track #(.ANGLE_BITS(ANGLE_BITS)) u_track (
      .clock         (clock),
      .reset         (reset),
      .fire          (advance && s1_valid_ff),
      .command       (s1_cmd_ff),
      .angle         (s1_angle_ff),
      .last_angle_in (last_angle_in),
      .turns_in      (turns_in),
      .zero_point_in (zero_point_in)
   );

   mau_result #(.ANGLE_BITS(ANGLE_BITS)) u_result (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .load_valid (s1_valid_ff),
      .last_angle (last_angle_in),
      .turns      (turns_in),
      .zero_point (zero_point_in),
      .rsp_bus    (rsp_bus)
   );

endmodule
